// File: rtl/cpm_pkg.sv
// ---------------------------------------------------------------------------
// cpm_pkg
// Shared types, constants and field-layout helpers for the cycling power
// measurement parser.
// ---------------------------------------------------------------------------
`default_nettype none

package cpm_pkg;

   // cadence arithmetic
   localparam int CADENCE_FRAC_BITS = 4;
   localparam int CAD_W             = 20;
   localparam logic [CAD_W-1:0] CADENCE_MAX = '1;
   localparam int CAD_SCALE         = 60 * 1024 * (1 << CADENCE_FRAC_BITS);
   localparam int SCALE_W           = $clog2(CAD_SCALE + 1);
   localparam logic [SCALE_W-1:0] SCALE_K = SCALE_W'(CAD_SCALE);
   localparam int DEN_W             = 16;
   localparam int NUM_W             = DEN_W + SCALE_W;
   localparam int HI_W              = NUM_W - CAD_W;
   localparam int CMP_W             = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam int DIV_CNT_W         = $clog2(CAD_W);

   // byte counting
   localparam int IDX_W             = 5;
   localparam logic [IDX_W-1:0] IDX_MAX   = '1;
   localparam logic [IDX_W-1:0] HEADER_LEN = IDX_W'(4);

   // command queue
   localparam int FIFO_DEPTH        = 4;
   localparam int FIFO_AW           = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW           = $clog2(FIFO_DEPTH + 1);

   // optional field layout, in packet order
   localparam int FIELD_COUNT = 5;
   localparam logic [3:0] FIELD_BIT [FIELD_COUNT] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd6};
   localparam logic [2:0] FIELD_LEN [FIELD_COUNT] = '{3'd1, 3'd2, 3'd6, 3'd4, 3'd4};

   // present mark bit positions
   localparam int MARK_BAL = 0;
   localparam int MARK_TRQ = 1;
   localparam int MARK_CAD = 2;
   localparam int MARK_FRC = 3;

   typedef enum logic [2:0] {
      FLD_NONE,
      FLD_BAL,
      FLD_TRQ,
      FLD_WHL,
      FLD_CRK,
      FLD_FRC
   } field_kind_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_BAL,
      CMD_TRQ,
      CMD_CRK,
      CMD_FRC
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_COMPLETE = 2'd0,
      ST_SHORT    = 2'd1,
      ST_TRUNC    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SAT,
      BK_DIV,
      BK_END
   } back_state_type;

   typedef struct packed {
      field_kind_type kind;
      logic [2:0]     pos;
      logic           last;
   } locate_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  data;
      logic         eop;
      status_type   status;
      logic [15:0]  power;
   } cmd_type;

   typedef struct packed {
      status_type          status;
      logic signed [15:0]  power_watts;
      logic                power_valid;
      logic [7:0]          balance_half_pct;
      logic                balance_present;
      logic [15:0]         torque_32nds;
      logic                torque_present;
      logic [CAD_W-1:0]    cadence_q4;
      logic                cadence_present;
      logic signed [15:0]  force_newtons;
      logic                force_present;
   } result_type;

   // find which optional field byte idx (>= 4) falls in
   function automatic locate_type locate_field(input logic [15:0]      flags,
                                               input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] start;
      locate_type       r;
      start  = HEADER_LEN;
      r.kind = FLD_NONE;
      r.pos  = '0;
      r.last = 1'b0;
      for (int k = 0; k < FIELD_COUNT; k++) begin
         if (flags[FIELD_BIT[k]] && (r.kind == FLD_NONE)) begin
            if (idx < start + IDX_W'(FIELD_LEN[k])) begin
               r.kind = field_kind_type'(3'(k + 1));
               r.pos  = 3'(idx - start);
               r.last = ((idx - start) == (IDX_W'(FIELD_LEN[k]) - IDX_W'(1)));
            end
            start = start + IDX_W'(FIELD_LEN[k]);
         end
      end
      return r;
   endfunction

   // bytes the flags announce
   function automatic logic [IDX_W-1:0] required_len(input logic [15:0] flags);
      logic [IDX_W-1:0] n;
      n = HEADER_LEN;
      for (int k = 0; k < FIELD_COUNT; k++) begin
         if (flags[FIELD_BIT[k]]) begin
            n = n + IDX_W'(FIELD_LEN[k]);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cpm_req_if.sv
// ---------------------------------------------------------------------------
// cpm_req_if
// Byte channel into the parser: valid/ready plus one packet byte.
// ---------------------------------------------------------------------------
`default_nettype none

interface cpm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       end_of_packet;

   modport source (output valid, output packet_byte, output end_of_packet, input ready);
   modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

`default_nettype wire

// File: rtl/cpm_rsp_if.sv
// ---------------------------------------------------------------------------
// cpm_rsp_if
// Result channel out of the parser: valid/ready plus one packet report.
// ---------------------------------------------------------------------------
`default_nettype none

interface cpm_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [15:0] power_watts;
   logic               power_valid;
   logic [7:0]         balance_half_pct;
   logic               balance_present;
   logic [15:0]        torque_32nds;
   logic               torque_present;
   logic [19:0]        cadence_q4;
   logic               cadence_present;
   logic signed [15:0] force_newtons;
   logic               force_present;

   modport source (output valid, input ready,
                   output status, output power_watts, output power_valid,
                   output balance_half_pct, output balance_present,
                   output torque_32nds, output torque_present,
                   output cadence_q4, output cadence_present,
                   output force_newtons, output force_present);
   modport sink   (input valid, output ready,
                   input status, input power_watts, input power_valid,
                   input balance_half_pct, input balance_present,
                   input torque_32nds, input torque_present,
                   input cadence_q4, input cadence_present,
                   input force_newtons, input force_present);
endinterface

`default_nettype wire

// File: rtl/cpm_cmd_fifo.sv
// ---------------------------------------------------------------------------
// cpm_cmd_fifo
// Short command queue between the byte front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module cpm_cmd_fifo
   import cpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         full,
   output logic         empty
);

   cmd_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + FIFO_AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cpm_front.sv
// ---------------------------------------------------------------------------
// cpm_front
// Byte front end: counts bytes, gathers the header and optional fields and
// issues one command on the fourth byte, the last byte and the end of any non-wheel field.
// ---------------------------------------------------------------------------
`default_nettype none

module cpm_front
   import cpm_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   cpm_req_if.sink     req_bus,
   output logic        push,
   output cmd_type     cmd,
   input  wire logic   full
);

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [15:0]      flag_word_ff, flag_word_in;
   logic [15:0]      pend_power_ff, pend_power_in;
   logic [31:0]      field_shift_ff, field_shift_in;
   logic             beat;

   assign req_bus.ready = !full;
   assign beat          = req_bus.valid && req_bus.ready;

   always_comb begin
      locate_type       loc;
      logic [IDX_W-1:0] idx_inc;
      logic [7:0]       b;
      b              = req_bus.packet_byte;
      loc.kind       = FLD_NONE;
      loc.pos        = '0;
      loc.last       = 1'b0;
      byte_index_in  = byte_index_ff;
      flag_word_in   = flag_word_ff;
      pend_power_in  = pend_power_ff;
      field_shift_in = field_shift_ff;
      cmd.kind       = CMD_NONE;
      cmd.eop        = req_bus.end_of_packet;

      priority if (byte_index_ff == IDX_W'(0)) begin
         flag_word_in = {8'h00, b};
      end else if (byte_index_ff == IDX_W'(1)) begin
         flag_word_in[15:8] = b;
      end else if (byte_index_ff == IDX_W'(2)) begin
         pend_power_in = {8'h00, b};
      end else if (byte_index_ff == IDX_W'(3)) begin
         pend_power_in[15:8] = b;
         cmd.kind            = CMD_CLEAR;
      end else begin
         loc = locate_field(flag_word_ff, byte_index_ff);
         if (loc.kind != FLD_NONE) begin
            if (loc.pos == 3'd0) begin
               field_shift_in = {24'h000000, b};
            end else if (loc.pos < 3'd4) begin
               field_shift_in[{loc.pos[1:0], 3'b000} +: 8] = b;
            end
            if (loc.last) begin
               unique case (loc.kind)
                  FLD_BAL: cmd.kind = CMD_BAL;
                  FLD_TRQ: cmd.kind = CMD_TRQ;
                  FLD_CRK: cmd.kind = CMD_CRK;
                  FLD_FRC: cmd.kind = CMD_FRC;
                  default: cmd.kind = CMD_NONE;
               endcase
            end
         end
      end

      idx_inc = (byte_index_ff == IDX_MAX) ? byte_index_ff : byte_index_ff + IDX_W'(1);
      byte_index_in = req_bus.end_of_packet ? '0 : idx_inc;

      // packet length check at the last byte
      priority if (idx_inc < HEADER_LEN) begin
         cmd.status = ST_SHORT;
      end else if (idx_inc < required_len(flag_word_ff)) begin
         cmd.status = ST_TRUNC;
      end else begin
         cmd.status = ST_COMPLETE;
      end

      cmd.data  = field_shift_in;
      cmd.power = pend_power_in;
      push      = beat && ((cmd.kind != CMD_NONE) || req_bus.end_of_packet);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= '0;
         flag_word_ff   <= '0;
         pend_power_ff  <= '0;
         field_shift_ff <= '0;
      end else if (beat) begin
         byte_index_ff  <= byte_index_in;
         flag_word_ff   <= flag_word_in;
         pend_power_ff  <= pend_power_in;
         field_shift_ff <= field_shift_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cpm_back.sv
// ---------------------------------------------------------------------------
// cpm_back
// Back end: applies queued commands to the held values, runs the cadence
// divider and registers the packet report.
// ---------------------------------------------------------------------------
`default_nettype none

module cpm_back
   import cpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire logic    empty,
   output logic         pop,
   cpm_rsp_if.source    rsp_bus
);

   back_state_type       state_ff, state_in;
   logic                 eop_ff, eop_in;
   status_type           status_ff, status_in;
   logic [15:0]          power_ff, power_in;

   logic [15:0]          held_power_ff, held_power_in;
   logic [7:0]           held_balance_ff, held_balance_in;
   logic [15:0]          held_torque_ff, held_torque_in;
   logic [CAD_W-1:0]     held_cadence_ff, held_cadence_in;
   logic [15:0]          held_force_ff, held_force_in;
   logic [3:0]           marks_ff, marks_in;
   logic                 data_seen_ff, data_seen_in;
   logic [15:0]          prev_revs_ff, prev_revs_in;
   logic [15:0]          prev_time_ff, prev_time_in;
   logic                 have_sample_ff, have_sample_in;

   logic [HI_W-1:0]      hi_ff, hi_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [CAD_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   always_comb begin
      logic [15:0]    drev;
      logic [15:0]    devt;
      logic [NUM_W-1:0] num;
      logic [DEN_W:0] trial;
      logic           ge;
      state_in        = state_ff;
      eop_in          = eop_ff;
      status_in       = status_ff;
      power_in        = power_ff;
      held_power_in   = held_power_ff;
      held_balance_in = held_balance_ff;
      held_torque_in  = held_torque_ff;
      held_cadence_in = held_cadence_ff;
      held_force_in   = held_force_ff;
      marks_in        = marks_ff;
      data_seen_in    = data_seen_ff;
      prev_revs_in    = prev_revs_ff;
      prev_time_in    = prev_time_ff;
      have_sample_in  = have_sample_ff;
      hi_in           = hi_ff;
      den_in          = den_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      cnt_in          = cnt_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      pop             = 1'b0;

      drev  = cmd.data[15:0] - prev_revs_ff;
      devt  = cmd.data[31:16] - prev_time_ff;
      num   = NUM_W'(drev) * NUM_W'(SCALE_K);
      trial = {rem_ff, quo_ff[CAD_W-1]};
      ge    = (trial >= {1'b0, den_ff});

      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               eop_in    = cmd.eop;
               status_in = cmd.status;
               power_in  = cmd.power;
               state_in  = cmd.eop ? BK_END : BK_IDLE;
               unique case (cmd.kind)
                  CMD_CLEAR: marks_in = '0;
                  CMD_BAL: begin
                     held_balance_in    = cmd.data[7:0];
                     marks_in[MARK_BAL] = 1'b1;
                  end
                  CMD_TRQ: begin
                     held_torque_in     = cmd.data[15:0];
                     marks_in[MARK_TRQ] = 1'b1;
                  end
                  CMD_FRC: begin
                     held_force_in      = cmd.data[15:0];
                     marks_in[MARK_FRC] = 1'b1;
                  end
                  CMD_CRK: begin
                     prev_revs_in   = cmd.data[15:0];
                     prev_time_in   = cmd.data[31:16];
                     have_sample_in = 1'b1;
                     if (have_sample_ff && (devt != '0)) begin
                        hi_in    = num[NUM_W-1:CAD_W];
                        quo_in   = num[CAD_W-1:0];
                        den_in   = devt;
                        state_in = BK_SAT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_SAT: begin
            // quotient overflows 20 bits exactly when the top part reaches the divisor
            if (CMP_W'(hi_ff) >= CMP_W'(den_ff)) begin
               held_cadence_in    = CADENCE_MAX;
               marks_in[MARK_CAD] = 1'b1;
               state_in           = eop_ff ? BK_END : BK_IDLE;
            end else begin
               rem_in   = DEN_W'(hi_ff);
               cnt_in   = '0;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            quo_in = {quo_ff[CAD_W-2:0], ge};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(CAD_W - 1)) begin
               held_cadence_in    = quo_in;
               marks_in[MARK_CAD] = 1'b1;
               state_in           = eop_ff ? BK_END : BK_IDLE;
            end
         end
         BK_END: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               if (status_ff == ST_COMPLETE) begin
                  held_power_in = power_ff;
                  data_seen_in  = 1'b1;
               end
               rsp_in.status           = status_ff;
               rsp_in.power_watts      = held_power_in;
               rsp_in.power_valid      = data_seen_in;
               rsp_in.balance_half_pct = held_balance_ff;
               rsp_in.balance_present  = marks_ff[MARK_BAL];
               rsp_in.torque_32nds     = held_torque_ff;
               rsp_in.torque_present   = marks_ff[MARK_TRQ];
               rsp_in.cadence_q4       = held_cadence_ff;
               rsp_in.cadence_present  = marks_ff[MARK_CAD];
               rsp_in.force_newtons    = held_force_ff;
               rsp_in.force_present    = marks_ff[MARK_FRC];
               rsp_valid_in            = 1'b1;
               state_in                = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= BK_IDLE;
         rsp_valid_ff    <= 1'b0;
         held_power_ff   <= '0;
         held_balance_ff <= '0;
         held_torque_ff  <= '0;
         held_cadence_ff <= '0;
         held_force_ff   <= '0;
         marks_ff        <= '0;
         data_seen_ff    <= 1'b0;
         prev_revs_ff    <= '0;
         prev_time_ff    <= '0;
         have_sample_ff  <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         held_power_ff   <= held_power_in;
         held_balance_ff <= held_balance_in;
         held_torque_ff  <= held_torque_in;
         held_cadence_ff <= held_cadence_in;
         held_force_ff   <= held_force_in;
         marks_ff        <= marks_in;
         data_seen_ff    <= data_seen_in;
         prev_revs_ff    <= prev_revs_in;
         prev_time_ff    <= prev_time_in;
         have_sample_ff  <= have_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      eop_ff    <= eop_in;
      status_ff <= status_in;
      power_ff  <= power_in;
      hi_ff     <= hi_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_ff.status;
   assign rsp_bus.power_watts      = rsp_ff.power_watts;
   assign rsp_bus.power_valid      = rsp_ff.power_valid;
   assign rsp_bus.balance_half_pct = rsp_ff.balance_half_pct;
   assign rsp_bus.balance_present  = rsp_ff.balance_present;
   assign rsp_bus.torque_32nds     = rsp_ff.torque_32nds;
   assign rsp_bus.torque_present   = rsp_ff.torque_present;
   assign rsp_bus.cadence_q4       = rsp_ff.cadence_q4;
   assign rsp_bus.cadence_present  = rsp_ff.cadence_present;
   assign rsp_bus.force_newtons    = rsp_ff.force_newtons;
   assign rsp_bus.force_present    = rsp_ff.force_present;

endmodule

`default_nettype wire

// File: rtl/cycling_power_measurement_parser_unit.sv
// ---------------------------------------------------------------------------
// cycling_power_measurement_parser_unit
// Byte-serial parser for cycling power measurement packets with cadence.
// ---------------------------------------------------------------------------
// The block takes one packet byte per beat on req_bus and gives one report
// beat on rsp_bus for every byte marked end_of_packet. The front end takes a
// byte every cycle while the command queue (four entries) has room; each byte
// that finishes a balance, torque, crank or force field, the fourth byte and
// the last byte post one command. The back end drains one command per cycle
// while idle, except a crank pair that needs a cadence divide (valid previous
// sample, non-zero time delta), which takes the pop, one saturation check and
// a 20-step restoring divider, the divider being skipped when the saturation
// check already settles it, and the end of a packet, which also loads the
// report register. The queue lets the front end keep taking bytes while the
// back end is busy. A report that waits for the sink holds the back end at
// the end of its packet; the queue still takes up to four commands, after
// which req_bus.ready drops until the beat is taken.
// Values in the report are the last stored ones; a present mark says the
// value was refreshed since the fourth byte of the latest packet that had
// one. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module cycling_power_measurement_parser_unit
   import cpm_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   cpm_req_if.sink     req_bus,
   cpm_rsp_if.source   rsp_bus
);

   // front to queue
   logic    cmd_push;
   cmd_type cmd_in;
   logic    cmd_full;

   // queue to back
   cmd_type cmd_out;
   logic    cmd_empty;
   logic    cmd_pop;

   // byte counting, header and field gathering
   cpm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .push    (cmd_push),
      .cmd     (cmd_in),
      .full    (cmd_full)
   );

   // decouples the byte stream from the divider
   cpm_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .full      (cmd_full),
      .empty     (cmd_empty)
   );

   // held values, cadence divide and report register
   cpm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd_out),
      .empty   (cmd_empty),
      .pop     (cmd_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// File: tb/cpm_report_check.sv
// ---------------------------------------------------------------------------
// cpm_report_check
// Watches the byte and report channels of the power measurement parser,
// predicts each report from the accepted bytes and compares it field by
// field with the report beat that arrives.
// ---------------------------------------------------------------------------

module cpm_report_check
   import cpm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   cpm_req_if        req_bus,
   cpm_rsp_if        rsp_bus,
   output int        mismatch_count,
   output int        reports_pending
);

   localparam int BAL_MARK = 0;
   localparam int TRQ_MARK = 1;
   localparam int CAD_MARK = 2;
   localparam int FRC_MARK = 3;
   localparam logic [63:0] CADENCE_SCALE = 64'(60 * 1024 * (1 << CADENCE_FRAC_BITS));
   localparam logic [19:0] CADENCE_CEIL  = 20'hFFFFF;

   // parser state as seen from the byte stream
   logic [4:0]  byte_count;
   logic [15:0] packet_flags;
   logic [15:0] packet_power;
   logic [31:0] field_bytes;
   logic [15:0] crank_revs_prev;
   logic [15:0] crank_time_prev;
   logic        crank_seen;
   logic [15:0] power_kept;
   logic [7:0]  balance_kept;
   logic [15:0] torque_kept;
   logic [19:0] cadence_kept;
   logic [15:0] force_kept;
   logic [3:0]  fresh_marks;
   logic        power_seen;
   result_type  expected_reports[$];

   function automatic int announced_len(input logic [15:0] flags);
      int n;
      n = 4;
      if (flags[0]) n += 1;
      if (flags[2]) n += 2;
      if (flags[4]) n += 6;
      if (flags[5]) n += 4;
      if (flags[6]) n += 4;
      return n;
   endfunction

   task automatic find_field(input logic [15:0] flags, input int idx,
                             output field_kind_type kind, output int pos, output int flen);
      int             start;
      int             fbit;
      int             n;
      field_kind_type k_kind;
      start = 4;
      kind  = FLD_NONE;
      pos   = 0;
      flen  = 0;
      for (int k = 0; k < 5; k++) begin
         case (k)
            0: begin fbit = 0; n = 1; k_kind = FLD_BAL; end
            1: begin fbit = 2; n = 2; k_kind = FLD_TRQ; end
            2: begin fbit = 4; n = 6; k_kind = FLD_WHL; end
            3: begin fbit = 5; n = 4; k_kind = FLD_CRK; end
            default: begin fbit = 6; n = 4; k_kind = FLD_FRC; end
         endcase
         if (flags[fbit] && (kind == FLD_NONE)) begin
            if (idx < start + n) begin
               kind = k_kind;
               pos  = idx - start;
               flen = n;
            end
            start += n;
         end
      end
   endtask

   task automatic crank_update(input logic [15:0] revs, input logic [15:0] evt);
      logic [15:0] drev;
      logic [15:0] devt;
      logic [63:0] quotient;
      if (crank_seen) begin
         drev = revs - crank_revs_prev;
         devt = evt - crank_time_prev;
         if (devt != 16'd0) begin
            quotient     = (CADENCE_SCALE * 64'(drev)) / 64'(devt);
            cadence_kept = (quotient > 64'(CADENCE_CEIL)) ? CADENCE_CEIL : quotient[19:0];
            fresh_marks[CAD_MARK] = 1'b1;
         end
      end
      crank_revs_prev = revs;
      crank_time_prev = evt;
      crank_seen      = 1'b1;
   endtask

   task automatic take_byte(input logic [7:0] b, input logic last);
      int             idx;
      field_kind_type kind;
      int             pos;
      int             flen;
      status_type     st;
      result_type     report;
      idx = byte_count;
      case (idx)
         0: packet_flags = {8'h00, b};
         1: packet_flags[15:8] = b;
         2: packet_power = {8'h00, b};
         3: begin
            packet_power[15:8] = b;
            fresh_marks = 4'b0000;
         end
         default: begin
            find_field(packet_flags, idx, kind, pos, flen);
            if (kind != FLD_NONE) begin
               if (pos == 0) field_bytes = {24'h0, b};
               else if (pos < 4) field_bytes[8*pos +: 8] = b;
               if (pos + 1 == flen) begin
                  case (kind)
                     FLD_BAL: begin
                        balance_kept = field_bytes[7:0];
                        fresh_marks[BAL_MARK] = 1'b1;
                     end
                     FLD_TRQ: begin
                        torque_kept = field_bytes[15:0];
                        fresh_marks[TRQ_MARK] = 1'b1;
                     end
                     FLD_CRK: crank_update(field_bytes[15:0], field_bytes[31:16]);
                     FLD_FRC: begin
                        force_kept = field_bytes[15:0];
                        fresh_marks[FRC_MARK] = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
         end
      endcase
      if (byte_count < 5'd31) byte_count++;
      if (last) begin
         if (byte_count < 5'd4) begin
            st = ST_SHORT;
         end else if (int'(byte_count) < announced_len(packet_flags)) begin
            st = ST_TRUNC;
         end else begin
            st         = ST_COMPLETE;
            power_kept = packet_power;
            power_seen = 1'b1;
         end
         byte_count              = 5'd0;
         report.status           = st;
         report.power_watts      = power_kept;
         report.power_valid      = power_seen;
         report.balance_half_pct = balance_kept;
         report.balance_present  = fresh_marks[BAL_MARK];
         report.torque_32nds     = torque_kept;
         report.torque_present   = fresh_marks[TRQ_MARK];
         report.cadence_q4       = cadence_kept;
         report.cadence_present  = fresh_marks[CAD_MARK];
         report.force_newtons    = force_kept;
         report.force_present    = fresh_marks[FRC_MARK];
         expected_reports.push_back(report);
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   task automatic compare_report();
      result_type want;
      if (expected_reports.size() == 0) begin
         $display("%0t: report beat with nothing outstanding, expected none, actual status %0d",
                  $time, rsp_bus.status);
         mismatch_count++;
      end else begin
         want = expected_reports.pop_front();
         check_field("status", want.status, rsp_bus.status);
         check_field("power_watts", $unsigned(want.power_watts),
                     $unsigned(rsp_bus.power_watts));
         check_field("power_valid", want.power_valid, rsp_bus.power_valid);
         check_field("balance_half_pct", want.balance_half_pct, rsp_bus.balance_half_pct);
         check_field("balance_present", want.balance_present, rsp_bus.balance_present);
         check_field("torque_32nds", want.torque_32nds, rsp_bus.torque_32nds);
         check_field("torque_present", want.torque_present, rsp_bus.torque_present);
         check_field("cadence_q4", want.cadence_q4, rsp_bus.cadence_q4);
         check_field("cadence_present", want.cadence_present, rsp_bus.cadence_present);
         check_field("force_newtons", $unsigned(want.force_newtons),
                     $unsigned(rsp_bus.force_newtons));
         check_field("force_present", want.force_present, rsp_bus.force_present);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         byte_count      = 5'd0;
         packet_flags    = 16'h0;
         packet_power    = 16'h0;
         field_bytes     = 32'h0;
         crank_revs_prev = 16'h0;
         crank_time_prev = 16'h0;
         crank_seen      = 1'b0;
         power_kept      = 16'h0;
         balance_kept    = 8'h0;
         torque_kept     = 16'h0;
         cadence_kept    = 20'h0;
         force_kept      = 16'h0;
         fresh_marks     = 4'b0000;
         power_seen      = 1'b0;
         mismatch_count  = 0;
         expected_reports.delete();
      end else begin
         // a report can never belong to the byte taken at the same edge
         if (rsp_bus.valid && rsp_bus.ready) compare_report();
         if (req_bus.valid && req_bus.ready)
            take_byte(req_bus.packet_byte, req_bus.end_of_packet);
      end
      reports_pending = expected_reports.size();
   end

endmodule

// File: tb/tb_cycling_power_measurement_parser_unit.sv
// ---------------------------------------------------------------------------
// tb_cycling_power_measurement_parser_unit
// Drives measurement packets byte by byte into the parser: a few hand-made
// packets first, then random packets, mostly well formed with some cut
// short, overlong or pure noise, under four phases of sender gaps and
// receiver back-pressure. A separate checker predicts every report.
// ---------------------------------------------------------------------------

module tb_cycling_power_measurement_parser_unit;
   import cpm_pkg::*;

   localparam int RANDOM_BYTES = 1530;  // spread evenly over the four phases

   logic clock;
   logic reset;

   cpm_req_if req_bus ();
   cpm_rsp_if rsp_bus ();

   int mismatches;
   int reports_pending;

   // idling percentages for the current phase
   int send_idle_pct;
   int ready_stall_pct;

   // packet under construction and stimulus bookkeeping
   logic [7:0]  packet_bytes[$];
   logic [15:0] last_revs_sent;
   logic [15:0] last_evt_sent;
   int          bytes_sent;

   cycling_power_measurement_parser_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   cpm_report_check u_report_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .mismatch_count  (mismatches),
      .reports_pending (reports_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle on the falling edge
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= ready_stall_pct);
   end

   // send the queued packet, end_of_packet on its final beat; valid stays
   // high from one beat to the next unless a gap is drawn
   task automatic send_packet();
      for (int i = 0; i < packet_bytes.size(); i++) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clock);
         end
         req_bus.valid         <= 1'b1;
         req_bus.packet_byte   <= packet_bytes[i];
         req_bus.end_of_packet <= (i == packet_bytes.size() - 1);
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         @(negedge clock);
         bytes_sent++;
      end
   endtask

   task automatic make_random_packet();
      int          shape;
      int          stop;
      int          target;
      logic [15:0] flags;
      logic [15:0] power;
      logic [15:0] revs;
      logic [15:0] evt;
      logic [7:0]  junk;
      shape = $urandom_range(99);
      flags = 16'($urandom);
      // lean towards packets that carry optional fields
      if ($urandom_range(3) != 0) flags[6:0] = flags[6:0] | (7'h75 & 7'($urandom));
      power = 16'($urandom);
      case ($urandom_range(7))
         0: power = 16'h8000;
         1: power = 16'h7FFF;
         default: ;
      endcase
      packet_bytes = '{flags[7:0], flags[15:8], power[7:0], power[15:8]};
      if (flags[0]) packet_bytes.push_back(8'($urandom));
      if (flags[2]) repeat (2) packet_bytes.push_back(8'($urandom));
      if (flags[4]) repeat (6) packet_bytes.push_back(8'($urandom));
      if (flags[5]) begin
         // crank pairs follow on from the previous one so cadence is sensible
         case ($urandom_range(7))
            0: begin
               revs = 16'($urandom);
               evt  = 16'($urandom);
            end
            1: begin
               // no time gap, so no cadence
               revs = last_revs_sent + 16'($urandom_range(0, 3));
               evt  = last_evt_sent;
            end
            2: begin
               // tiny time gap, often pushes the quotient into saturation
               revs = last_revs_sent + 16'($urandom_range(1, 8));
               evt  = last_evt_sent + 16'($urandom_range(1, 4));
            end
            default: begin
               revs = last_revs_sent + 16'($urandom_range(0, 4));
               evt  = last_evt_sent + 16'($urandom_range(300, 3000));
            end
         endcase
         last_revs_sent = revs;
         last_evt_sent  = evt;
         packet_bytes.push_back(revs[7:0]);
         packet_bytes.push_back(revs[15:8]);
         packet_bytes.push_back(evt[7:0]);
         packet_bytes.push_back(evt[15:8]);
      end
      if (flags[6]) repeat (4) packet_bytes.push_back(8'($urandom));

      if (shape < 68) begin
         // well formed, now and then with trailing bytes the flags never asked for
         if ($urandom_range(6) == 0)
            repeat ($urandom_range(1, 4)) packet_bytes.push_back(8'($urandom));
      end else if (shape < 80) begin
         // cut inside the optional fields
         if (packet_bytes.size() > 4) begin
            stop = $urandom_range(4, packet_bytes.size() - 1);
            while (packet_bytes.size() > stop) junk = packet_bytes.pop_back();
         end
      end else if (shape < 88) begin
         // shorter than the header
         stop = $urandom_range(1, 3);
         while (packet_bytes.size() > stop) junk = packet_bytes.pop_back();
      end else if (shape < 93) begin
         // runs past the point where the byte count saturates
         target = $urandom_range(32, 40);
         while (packet_bytes.size() < target) packet_bytes.push_back(8'($urandom));
      end else begin
         // pure noise
         packet_bytes.delete();
         repeat ($urandom_range(1, 26)) packet_bytes.push_back(8'($urandom));
      end
   endtask

   initial begin
      int phase_end;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.packet_byte   = 8'h00;
      req_bus.end_of_packet = 1'b0;
      rsp_bus.ready         = 1'b0;
      send_idle_pct         = 0;
      ready_stall_pct       = 0;
      last_revs_sent        = 16'h0;
      last_evt_sent         = 16'h0;
      bytes_sent            = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed packets, no idling
      // a lone byte: shorter than the header
      packet_bytes = '{8'h01};
      send_packet();
      // only unused flag bits set, largest positive power
      packet_bytes = '{8'h80, 8'hFF, 8'hFF, 8'h7F};
      send_packet();
      // first crank sample gives no cadence, most negative power
      packet_bytes = '{8'h20, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00};
      send_packet();
      // balance and torque land, then the crank pair is cut after one beat
      packet_bytes = '{8'h65, 8'h00, 8'h34, 8'h12, 8'h00, 8'hFF, 8'hFF, 8'h02};
      send_packet();
      // bare header: marks clear, stale values stay
      packet_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
      send_packet();
      last_revs_sent = 16'hFFFF;
      last_evt_sent  = 16'h0000;

      // random packets under each idling phase in turn
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
            1: begin send_idle_pct = 52; ready_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  ready_stall_pct = 52; end
            default: begin send_idle_pct = 20; ready_stall_pct = 20; end
         endcase
         phase_end = bytes_sent + RANDOM_BYTES / 4;
         while (bytes_sent < phase_end) begin
            make_random_packet();
            send_packet();
         end
      end
      req_bus.valid <= 1'b0;

      // drain the reports, then allow for a crank division still in flight
      wait (reports_pending == 0);
      repeat (60) @(posedge clock);
      if ((mismatches == 0) && (reports_pending == 0)) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
